// File: sv/adcm_pkg.sv
`default_nettype none

package adcm_pkg;

  function automatic int unsigned max_u(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

  // Field widths of the channels and registers.
  localparam int unsigned CaptureWidth  = 16;
  localparam int unsigned FreqWidth     = 28;
  localparam int unsigned ClockHzWidth  = 28;
  localparam int unsigned TargetWidth   = 16;
  localparam int unsigned PrescWidth    = 16;
  localparam int unsigned TimeoutWidth  = 16;
  localparam int unsigned DutyWidth     = 10;
  localparam int unsigned PeriodNsWidth = 30;
  localparam int unsigned CmdWidth      = 2;

  // Configuration port.
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned RegIdWidth = 2;

  localparam logic [RegIdWidth-1:0] RegClockHz  = 2'd0;
  localparam logic [RegIdWidth-1:0] RegTarget   = 2'd1;
  localparam logic [RegIdWidth-1:0] RegDefPresc = 2'd2;
  localparam logic [RegIdWidth-1:0] RegTimeout  = 2'd3;

  localparam logic [ClockHzWidth-1:0] ClockHzReset  = ClockHzWidth'(72000000);
  localparam logic [TargetWidth-1:0]  TargetReset   = TargetWidth'(60000);
  localparam logic [PrescWidth-1:0]   DefPrescReset = PrescWidth'(1199);
  localparam logic [TimeoutWidth-1:0] TimeoutReset  = TimeoutWidth'(1500);

  // Commands.
  localparam logic [CmdWidth-1:0] CmdStart   = 2'd0;
  localparam logic [CmdWidth-1:0] CmdCapture = 2'd1;
  localparam logic [CmdWidth-1:0] CmdGate    = 2'd2;
  localparam logic [CmdWidth-1:0] CmdTick    = 2'd3;

  // Shared multiplier and divider sizing.
  localparam int unsigned MulAWidth = max_u(CaptureWidth, FreqWidth);
  localparam int unsigned MulBWidth = TargetWidth;
  localparam int unsigned MulPWidth = MulAWidth + MulBWidth;
  localparam int unsigned NumWidth  = max_u(CaptureWidth + DutyWidth, 32);
  localparam int unsigned DenWidth  = max_u(CaptureWidth, FreqWidth + TargetWidth);
  localparam int unsigned CntWidth  = $clog2(NumWidth);

  localparam int unsigned PermilleScale = 1000;
  localparam longint unsigned NsPerSecond = 64'd1000000000;
  localparam longint unsigned DividerMax  = 64'd65536;

  typedef struct packed {
    logic [CmdWidth-1:0]     command;
    logic [CaptureWidth-1:0] period_ticks;
    logic [CaptureWidth-1:0] high_ticks;
    logic [FreqWidth-1:0]    measured_hz;
  } in_item_t;

  typedef struct packed {
    logic [DutyWidth-1:0]     duty_permille;
    logic                     duty_ok;
    logic [PrescWidth-1:0]    prescaler_now;
    logic                     prescaler_changed;
    logic [FreqWidth-1:0]     frequency_out_hz;
    logic [PeriodNsWidth-1:0] period_ns;
  } out_item_t;

  typedef struct packed {
    logic [ClockHzWidth-1:0] counter_clock_hz;
    logic [TargetWidth-1:0]  target_period_ticks;
    logic [PrescWidth-1:0]   default_prescaler;
    logic [TimeoutWidth-1:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                start;
    logic [NumWidth-1:0] num;
    logic [DenWidth-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NumWidth-1:0] quo;
    logic [DenWidth-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: sv/adcm_regs.sv
`default_nettype none

module adcm_regs import adcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output cfg_t                 cfg_o
);

  cfg_t                  cfg_q;
  logic                  wr_en;
  logic [RegIdWidth-1:0] reg_id;

  assign wr_en  = psel & penable & pwrite;
  assign reg_id = paddr[AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counter_clock_hz    <= ClockHzReset;
      cfg_q.target_period_ticks <= TargetReset;
      cfg_q.default_prescaler   <= DefPrescReset;
      cfg_q.timeout_ms          <= TimeoutReset;
    end else if (wr_en) begin
      unique case (reg_id)
        RegClockHz:  cfg_q.counter_clock_hz    <= pwdata[ClockHzWidth-1:0];
        RegTarget:   cfg_q.target_period_ticks <= pwdata[TargetWidth-1:0];
        RegDefPresc: cfg_q.default_prescaler   <= pwdata[PrescWidth-1:0];
        RegTimeout:  cfg_q.timeout_ms          <= pwdata[TimeoutWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_id)
      RegClockHz:  prdata = DataWidth'(cfg_q.counter_clock_hz);
      RegTarget:   prdata = DataWidth'(cfg_q.target_period_ticks);
      RegDefPresc: prdata = DataWidth'(cfg_q.default_prescaler);
      RegTimeout:  prdata = DataWidth'(cfg_q.timeout_ms);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/adcm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module adcm_div import adcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [NumWidth-1:0] acc_q;
  logic [DenWidth-1:0] rem_q;
  logic [DenWidth-1:0] den_q;

  logic [DenWidth:0]   rem_sh;
  logic [DenWidth:0]   rem_nx;
  logic                fits;

  assign rem_sh = {rem_q, acc_q[NumWidth-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntWidth'(NumWidth - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      acc_q <= {acc_q[NumWidth-2:0], fits};
      rem_q <= rem_nx[DenWidth-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// File: sv/adcm_seq.sv
`default_nettype none

module adcm_seq import adcm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  input  logic      out_free_i,
  output logic      res_valid_o,
  output out_item_t res_data_o,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StMul    = 3'd1;
  localparam logic [2:0] StDivGo  = 3'd2;
  localparam logic [2:0] StDivRun = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  localparam logic [1:0] PhDuty = 2'd0;
  localparam logic [1:0] PhPres = 2'd1;
  localparam logic [1:0] PhPns  = 2'd2;

  localparam logic [MulBWidth-1:0]    PermilleMul = MulBWidth'(PermilleScale);
  localparam logic [NumWidth-1:0]     NsConst     = NumWidth'(NsPerSecond);
  localparam logic [NumWidth:0]       DivMaxC     = (NumWidth + 1)'(DividerMax);
  localparam logic [TimeoutWidth-1:0] ElapsedMax  = '1;

  logic [2:0]               state_q, state_d;
  logic [1:0]               phase_q, phase_d;
  in_item_t                 item_q, item_d;
  logic [MulPWidth-1:0]     prod_q, prod_d;
  logic [PrescWidth-1:0]    np_q, np_d;
  logic [PrescWidth-1:0]    pres_q, pres_d;
  logic                     synced_q, synced_d;
  logic                     valid_q, valid_d;
  logic [DutyWidth-1:0]     duty_q, duty_d;
  logic [TimeoutWidth-1:0]  elapsed_q, elapsed_d;
  logic [FreqWidth-1:0]     freq_q, freq_d;
  logic [PeriodNsWidth-1:0] pns_q, pns_d;
  logic                     changed_q, changed_d;

  logic [FreqWidth-1:0]     lower;
  logic [TargetWidth-1:0]   target;
  logic [MulAWidth-1:0]     mul_a;
  logic [MulBWidth-1:0]     mul_b;
  logic [NumWidth:0]        div_full;
  logic [PrescWidth-1:0]    np_calc;
  logic [TimeoutWidth-1:0]  elapsed_inc;
  logic                     div_start;

  // Multiplier operands: high time by 1000 for a capture, max(f-1, 1) by target otherwise.
  assign lower  = (item_q.measured_hz > FreqWidth'(1)) ? (item_q.measured_hz - 1'b1)
                                                       : FreqWidth'(1);
  assign target = (cfg_i.target_period_ticks == '0) ? TargetWidth'(1)
                                                    : cfg_i.target_period_ticks;
  assign mul_a  = (item_q.command == CmdCapture) ? MulAWidth'(item_q.high_ticks)
                                                 : MulAWidth'(lower);
  assign mul_b  = (item_q.command == CmdCapture) ? PermilleMul : target;

  // Ceiling of the clock over the denominator, clamped, minus one.
  assign div_full = {1'b0, div_rsp_i.quo} + (NumWidth + 1)'(div_rsp_i.rem != '0);
  always_comb begin
    if (div_full == '0) begin
      np_calc = '0;
    end else if (div_full > DivMaxC) begin
      np_calc = '1;
    end else begin
      np_calc = PrescWidth'(div_full - 1'b1);
    end
  end

  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : (elapsed_q + 1'b1);

  always_comb begin
    div_req_o.start = div_start;
    unique case (phase_q)
      PhDuty: begin
        div_req_o.num = NumWidth'(prod_q) + NumWidth'(item_q.period_ticks >> 1);
        div_req_o.den = DenWidth'(item_q.period_ticks);
      end
      PhPres: begin
        div_req_o.num = NumWidth'(cfg_i.counter_clock_hz);
        div_req_o.den = DenWidth'(prod_q);
      end
      default: begin
        div_req_o.num = NsConst + NumWidth'(item_q.measured_hz >> 1);
        div_req_o.den = DenWidth'(item_q.measured_hz);
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    item_d    = item_q;
    prod_d    = prod_q;
    np_d      = np_q;
    pres_d    = pres_q;
    synced_d  = synced_q;
    valid_d   = valid_q;
    duty_d    = duty_q;
    elapsed_d = elapsed_q;
    freq_d    = freq_q;
    pns_d     = pns_q;
    changed_d = changed_q;
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    in_ready_o  = (state_q == StIdle);

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          changed_d = 1'b0;
          state_d   = StDone;
          unique case (in_data_i.command)
            CmdStart: begin
              if (in_data_i.measured_hz == '0) begin
                pres_d    = cfg_i.default_prescaler;
                synced_d  = 1'b0;
                valid_d   = 1'b0;
                duty_d    = '0;
                elapsed_d = '0;
                freq_d    = '0;
                pns_d     = '0;
                changed_d = 1'b1;
              end else begin
                phase_d = PhPres;
                state_d = StMul;
              end
            end
            CmdCapture: begin
              if (!synced_q) begin
                synced_d = 1'b1;
              end else if (in_data_i.period_ticks == '0 ||
                           in_data_i.high_ticks > in_data_i.period_ticks) begin
                valid_d = 1'b0;
              end else begin
                phase_d = PhDuty;
                state_d = StMul;
              end
            end
            CmdGate: begin
              if (in_data_i.measured_hz == '0) begin
                freq_d = '0;
                pns_d  = '0;
              end else begin
                phase_d = PhPres;
                state_d = StMul;
              end
            end
            CmdTick: begin
              if (valid_q && elapsed_inc > cfg_i.timeout_ms) begin
                synced_d  = 1'b0;
                valid_d   = 1'b0;
                duty_d    = '0;
                elapsed_d = '0;
              end else begin
                elapsed_d = elapsed_inc;
              end
            end
            default: ;
          endcase
        end
      end
      StMul: begin
        prod_d  = MulPWidth'(mul_a) * MulPWidth'(mul_b);
        state_d = StDivGo;
      end
      StDivGo: begin
        div_start = 1'b1;
        state_d   = StDivRun;
      end
      StDivRun: begin
        if (div_rsp_i.done) begin
          state_d = StDone;
          unique case (phase_q)
            PhDuty: begin
              duty_d    = div_rsp_i.quo[DutyWidth-1:0];
              elapsed_d = '0;
              valid_d   = 1'b1;
            end
            PhPres: begin
              if (item_q.command == CmdStart) begin
                pres_d    = np_calc;
                synced_d  = 1'b0;
                valid_d   = 1'b0;
                duty_d    = '0;
                elapsed_d = '0;
                freq_d    = '0;
                pns_d     = '0;
                changed_d = 1'b1;
              end else begin
                np_d    = np_calc;
                phase_d = PhPns;
                state_d = StDivGo;
              end
            end
            default: begin
              freq_d = item_q.measured_hz;
              pns_d  = div_rsp_i.quo[PeriodNsWidth-1:0];
              if (np_q != pres_q) begin
                pres_d    = np_q;
                synced_d  = 1'b0;
                valid_d   = 1'b0;
                duty_d    = '0;
                elapsed_d = '0;
                changed_d = 1'b1;
              end
            end
          endcase
        end
      end
      StDone: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      phase_q   <= PhDuty;
      pres_q    <= DefPrescReset;
      synced_q  <= 1'b0;
      valid_q   <= 1'b0;
      duty_q    <= '0;
      elapsed_q <= '0;
      freq_q    <= '0;
      pns_q     <= '0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      pres_q    <= pres_d;
      synced_q  <= synced_d;
      valid_q   <= valid_d;
      duty_q    <= duty_d;
      elapsed_q <= elapsed_d;
      freq_q    <= freq_d;
      pns_q     <= pns_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prod_q <= prod_d;
    np_q   <= np_d;
  end

  assign res_data_o.duty_permille     = duty_q;
  assign res_data_o.duty_ok           = valid_q;
  assign res_data_o.prescaler_now     = pres_q;
  assign res_data_o.prescaler_changed = changed_q;
  assign res_data_o.frequency_out_hz  = freq_q;
  assign res_data_o.period_ns         = pns_q;

endmodule

`default_nettype wire

// File: sv/autorange_duty_cycle_meter.sv
`default_nettype none

// Autoranging PWM duty-cycle meter.
// Commands arrive on the input channel (valid/ready), one per transfer: start,
// capture pair, gate frequency or millisecond tick. Every command produces
// exactly one result transfer on the output channel carrying the duty in
// permille, its validity, the prescaler for the capture counter, a changed
// flag, the last gate frequency and its rounded period in nanoseconds.
// Ticks, hintless starts, zero-frequency gates and dropped or bad captures go
// straight from idle to the done state. A good capture and a start with a hint
// take one multiply and one pass of the shared 32-step restoring divider before
// the result moves to the output register; a gate runs the divider twice
// (prescaler, then period). One command is in flight at a time; the
// input is ready again the cycle after its result moves into the output register.
// The output register lets a new command be accepted while the previous
// result waits; a stalled receiver holds the result steady and blocks the
// following result from leaving the sequencer.
// Reset loads the configuration defaults and the start-up prescaler, clears the
// capture state and leaves both channels empty. The user must write configuration
// through the APB port only while no command is in flight; nothing enforces it.
module autorange_duty_cycle_meter import adcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t      cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      res_valid;
  out_item_t res_data;
  logic      out_free;
  logic      out_valid_q;
  out_item_t out_data_q;

  assign pready = 1'b1;

  adcm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  adcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  adcm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  // The output slot is free when empty or when its result leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: sv/adcm_checker.sv
`default_nettype none

module adcm_checker import adcm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  localparam logic [DutyWidth-1:0] DutyMax = DutyWidth'(PermilleScale);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one command is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // The rounded duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty_permille <= DutyMax)
    else $error("duty above 1000 permille");

endmodule

bind autorange_duty_cycle_meter adcm_checker u_adcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
